>>> sv/tool_path_length_accumulator_assert.svh
// Assertion macros shared by the odometer RTL.
// Each macro takes a label, the clock, the active-low reset, a condition,
// a consequence and a message.
`ifndef TOOL_PATH_LENGTH_ACCUMULATOR_ASSERT_SVH
`define TOOL_PATH_LENGTH_ACCUMULATOR_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define TPLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define TPLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tpla_pkg.sv
package tpla_pkg;

    // Field widths.
    localparam int POSITION_BITS = 24;
    localparam int TIME_BITS     = 40;
    localparam int TOTAL_BITS    = 48;
    localparam int SPEED_BITS    = 16;
    localparam int REQ_BITS      = 2;

    // Distance arithmetic widths.
    localparam int DIFF_BITS = POSITION_BITS;
    localparam int ROOT_BITS = DIFF_BITS + 1;
    localparam int SQ_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int CNT_BITS  = $clog2(ROOT_BITS);

    // Speed test: dist * SCALE < max_speed * 2^SPEED_SHIFT * dt.
    localparam int SCALE        = 1000000;
    localparam int SCALE_BITS   = 20;
    localparam int SPEED_SHIFT  = 7;
    localparam int TIME_LO_BITS = (TIME_BITS + 1) / 2;
    localparam int TIME_HI_BITS = TIME_BITS - TIME_LO_BITS;
    localparam int LHS_BITS     = ROOT_BITS + SCALE_BITS;
    localparam int RHS_BITS     = SPEED_BITS + TIME_BITS;
    localparam int CMP_BITS     = (LHS_BITS > RHS_BITS + SPEED_SHIFT) ?
                                  LHS_BITS : RHS_BITS + SPEED_SHIFT;

    // Shared multiplier operand width.
    localparam int MUL_AB    = (ROOT_BITS > TIME_LO_BITS) ? ROOT_BITS : TIME_LO_BITS;
    localparam int MUL_BITS  = (MUL_AB > SCALE_BITS) ? MUL_AB : SCALE_BITS;
    localparam int PROD_BITS = 2 * MUL_BITS;

    // Stream widths, padded to whole bytes.
    localparam int IN_FIELD_BITS  = 3 * POSITION_BITS + TIME_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * TOTAL_BITS + 2;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = SPEED_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RECORDING_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_SPEED        = 1'd1;
    localparam logic [SPEED_BITS-1:0]     MAX_SPEED_RESET      = 16'd500;

    // Request kinds.
    localparam logic [REQ_BITS-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_ENTER  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_LEAVE  = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd3;

    // Datapath operations.
    localparam int OP_BITS = 4;
    localparam logic [OP_BITS-1:0] OP_PREP = 4'd0;
    localparam logic [OP_BITS-1:0] OP_SQX  = 4'd1;
    localparam logic [OP_BITS-1:0] OP_SQY  = 4'd2;
    localparam logic [OP_BITS-1:0] OP_SQZ  = 4'd3;
    localparam logic [OP_BITS-1:0] OP_SUM  = 4'd4;
    localparam logic [OP_BITS-1:0] OP_ROOT = 4'd5;
    localparam logic [OP_BITS-1:0] OP_RND  = 4'd6;
    localparam logic [OP_BITS-1:0] OP_MLO  = 4'd7;
    localparam logic [OP_BITS-1:0] OP_MHI  = 4'd8;
    localparam logic [OP_BITS-1:0] OP_MLH  = 4'd9;
    localparam logic [OP_BITS-1:0] OP_CMP  = 4'd10;
    localparam logic [OP_BITS-1:0] OP_ADD  = 4'd11;
    localparam logic [OP_BITS-1:0] OP_DONE = 4'd12;

    // Sequencing conditions.
    localparam int COND_BITS = 2;
    localparam logic [COND_BITS-1:0] COND_NEXT = 2'd0;
    localparam logic [COND_BITS-1:0] COND_SKIP = 2'd1;
    localparam logic [COND_BITS-1:0] COND_LOOP = 2'd2;
    localparam logic [COND_BITS-1:0] COND_WAIT = 2'd3;

    localparam int PC_BITS = 4;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [COND_BITS-1:0] cond;
        logic [PC_BITS-1:0]   target;
        logic                 last;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic               exec;
        logic [OP_BITS-1:0] op;
    } t_ctrl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic no_step;
        logic cnt_zero;
    } t_stat;

    // One result beat.
    typedef struct packed {
        logic                  inside_flag;
        logic                  step_added;
        logic [TOTAL_BITS-1:0] total_path_inside;
        logic [TOTAL_BITS-1:0] total_path;
    } t_res;

    // Microprogram: one control word per step.
    function automatic t_uword ucode_rom(input logic [PC_BITS-1:0] pc);
        t_uword w;
        begin
            case (pc)
                4'd0:    w = '{OP_PREP, COND_SKIP, 4'd12, 1'b0};
                4'd1:    w = '{OP_SQX,  COND_NEXT, 4'd0,  1'b0};
                4'd2:    w = '{OP_SQY,  COND_NEXT, 4'd0,  1'b0};
                4'd3:    w = '{OP_SQZ,  COND_NEXT, 4'd0,  1'b0};
                4'd4:    w = '{OP_SUM,  COND_NEXT, 4'd0,  1'b0};
                4'd5:    w = '{OP_ROOT, COND_LOOP, 4'd5,  1'b0};
                4'd6:    w = '{OP_RND,  COND_NEXT, 4'd0,  1'b0};
                4'd7:    w = '{OP_MLO,  COND_NEXT, 4'd0,  1'b0};
                4'd8:    w = '{OP_MHI,  COND_NEXT, 4'd0,  1'b0};
                4'd9:    w = '{OP_MLH,  COND_NEXT, 4'd0,  1'b0};
                4'd10:   w = '{OP_CMP,  COND_NEXT, 4'd0,  1'b0};
                4'd11:   w = '{OP_ADD,  COND_NEXT, 4'd0,  1'b0};
                4'd12:   w = '{OP_DONE, COND_WAIT, 4'd0,  1'b1};
                default: w = '{OP_DONE, COND_WAIT, 4'd0,  1'b1};
            endcase
            return w;
        end
    endfunction

endpackage

>>> sv/tpla_seq.sv
module tpla_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_out_hold,
    input  tpla_pkg::t_stat i_stat,
    output logic            o_busy,
    output tpla_pkg::t_ctrl o_ctrl
);

    logic                         r_busy, n_busy;
    logic [tpla_pkg::PC_BITS-1:0] r_pc, n_pc;
    tpla_pkg::t_uword             uw;
    logic                         hold;
    logic                         take;
    logic                         exec;

    // Decode the current control word.
    always_comb begin
        uw   = tpla_pkg::ucode_rom(r_pc);
        hold = (uw.cond == tpla_pkg::COND_WAIT) && i_out_hold;
        take = ((uw.cond == tpla_pkg::COND_SKIP) && i_stat.no_step) ||
               ((uw.cond == tpla_pkg::COND_LOOP) && !i_stat.cnt_zero);
        exec = r_busy && !hold;
    end

    // Step counter and busy flag.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = '0;
            end
        end else if (exec) begin
            if (uw.last) begin
                n_busy = 1'b0;
            end else if (take) begin
                n_pc = uw.target;
            end else begin
                n_pc = r_pc + tpla_pkg::PC_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy      = r_busy;
    assign o_ctrl.exec = exec;
    assign o_ctrl.op   = uw.op;

endmodule

>>> sv/tpla_dp.sv
module tpla_dp (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_load,
    input  logic [tpla_pkg::REQ_BITS-1:0]             i_req,
    input  logic signed [tpla_pkg::POSITION_BITS-1:0] i_pos_x,
    input  logic signed [tpla_pkg::POSITION_BITS-1:0] i_pos_y,
    input  logic signed [tpla_pkg::POSITION_BITS-1:0] i_pos_z,
    input  logic [tpla_pkg::TIME_BITS-1:0]            i_time,
    input  logic                                      i_rec_en,
    input  logic [tpla_pkg::SPEED_BITS-1:0]           i_max_speed,
    input  tpla_pkg::t_ctrl                           i_ctrl,
    output tpla_pkg::t_stat                           o_stat,
    output tpla_pkg::t_res                            o_res
);

    localparam int P = tpla_pkg::POSITION_BITS;

    // Magnitude of the difference of two signed positions.
    function automatic logic [tpla_pkg::DIFF_BITS-1:0] abs_diff(
        input logic [P-1:0] a,
        input logic [P-1:0] b
    );
        logic [P:0] d;
        logic [P:0] m;
        begin
            d = {a[P-1], a} - {b[P-1], b};
            m = d[P] ? (~d + (P + 1)'(1)) : d;
            return m[P-1:0];
        end
    endfunction

    // Add a step to a total, sticking at all ones.
    function automatic logic [tpla_pkg::TOTAL_BITS-1:0] sat_add(
        input logic [tpla_pkg::TOTAL_BITS-1:0] t,
        input logic [tpla_pkg::ROOT_BITS-1:0]  d
    );
        logic [tpla_pkg::TOTAL_BITS:0] s;
        begin
            s = {1'b0, t} + (tpla_pkg::TOTAL_BITS + 1)'(d);
            return s[tpla_pkg::TOTAL_BITS] ? '1 : s[tpla_pkg::TOTAL_BITS-1:0];
        end
    endfunction

    // Captured item.
    logic [tpla_pkg::REQ_BITS-1:0]  r_req;
    logic [P-1:0]                   r_x, r_y, r_z;
    logic [tpla_pkg::TIME_BITS-1:0] r_t;

    // Tracking state.
    logic [P-1:0]                    r_last_x, r_last_y, r_last_z;
    logic [tpla_pkg::TIME_BITS-1:0]  r_last_t;
    logic                            r_have_last;
    logic [tpla_pkg::TOTAL_BITS-1:0] r_path, r_path_in;
    logic                            r_inside;

    // Working registers.
    logic [tpla_pkg::DIFF_BITS-1:0] r_dx, r_dy, r_dz;
    logic [tpla_pkg::TIME_BITS-1:0] r_dt;
    logic [tpla_pkg::SQ_BITS-1:0]   r_acc;
    logic [tpla_pkg::REM_BITS-1:0]  r_rem;
    logic [tpla_pkg::ROOT_BITS-1:0] r_root;
    logic [tpla_pkg::CNT_BITS-1:0]  r_cnt;
    logic [tpla_pkg::PROD_BITS-1:0] r_prod;
    logic [tpla_pkg::RHS_BITS-1:0]  r_rhs;
    logic                           r_pass;

    logic [tpla_pkg::MUL_BITS-1:0]  mul_a, mul_b;
    logic [tpla_pkg::PROD_BITS-1:0] mul_p;
    logic [tpla_pkg::REM_BITS-1:0]  rem_sh, trial;
    logic [tpla_pkg::CMP_BITS-1:0]  cmp_l, cmp_r;
    logic                           is_sample;

    assign is_sample = (r_req == tpla_pkg::REQ_SAMPLE) && i_rec_en;

    // A sample measures a step only with recording enabled, a previous position and a later time.
    assign o_stat.no_step  = !(is_sample && r_have_last && (r_t > r_last_t));
    assign o_stat.cnt_zero = (r_cnt == '0);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.op)
            tpla_pkg::OP_SQX: begin
                mul_a = tpla_pkg::MUL_BITS'(r_dx);
                mul_b = tpla_pkg::MUL_BITS'(r_dx);
            end
            tpla_pkg::OP_SQY: begin
                mul_a = tpla_pkg::MUL_BITS'(r_dy);
                mul_b = tpla_pkg::MUL_BITS'(r_dy);
            end
            tpla_pkg::OP_SQZ: begin
                mul_a = tpla_pkg::MUL_BITS'(r_dz);
                mul_b = tpla_pkg::MUL_BITS'(r_dz);
            end
            tpla_pkg::OP_MLO: begin
                mul_a = tpla_pkg::MUL_BITS'(i_max_speed);
                mul_b = tpla_pkg::MUL_BITS'(r_dt[tpla_pkg::TIME_LO_BITS-1:0]);
            end
            tpla_pkg::OP_MHI: begin
                mul_a = tpla_pkg::MUL_BITS'(i_max_speed);
                mul_b = tpla_pkg::MUL_BITS'(r_dt[tpla_pkg::TIME_BITS-1:tpla_pkg::TIME_LO_BITS]);
            end
            tpla_pkg::OP_MLH: begin
                mul_a = tpla_pkg::MUL_BITS'(r_root);
                mul_b = tpla_pkg::MUL_BITS'(tpla_pkg::SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One square-root digit: bring down two radicand bits and try the next root bit.
    assign rem_sh = {r_rem[tpla_pkg::REM_BITS-3:0],
                     r_acc[tpla_pkg::SQ_BITS-1:tpla_pkg::SQ_BITS-2]};
    assign trial  = tpla_pkg::REM_BITS'({r_root, 2'b01});

    // Speed test operands.
    assign cmp_l = tpla_pkg::CMP_BITS'(r_prod[tpla_pkg::LHS_BITS-1:0]);
    assign cmp_r = tpla_pkg::CMP_BITS'(r_rhs) << tpla_pkg::SPEED_SHIFT;

    // Result as it stands once the finishing step is done.
    always_comb begin
        o_res.total_path        = r_path;
        o_res.total_path_inside = r_path_in;
        o_res.step_added        = r_pass;
        o_res.inside_flag       = r_inside;
        case (r_req)
            tpla_pkg::REQ_ENTER: o_res.inside_flag = 1'b1;
            tpla_pkg::REQ_LEAVE: o_res.inside_flag = 1'b0;
            tpla_pkg::REQ_CLEAR: begin
                o_res.total_path        = '0;
                o_res.total_path_inside = '0;
            end
            default: o_res.inside_flag = r_inside;
        endcase
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= i_req;
            r_x   <= i_pos_x;
            r_y   <= i_pos_y;
            r_z   <= i_pos_z;
            r_t   <= i_time;
        end
    end

    // Arithmetic steps.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            case (i_ctrl.op)
                tpla_pkg::OP_PREP: begin
                    r_dx   <= abs_diff(r_x, r_last_x);
                    r_dy   <= abs_diff(r_y, r_last_y);
                    r_dz   <= abs_diff(r_z, r_last_z);
                    r_dt   <= r_t - r_last_t;
                    r_pass <= 1'b0;
                end
                tpla_pkg::OP_SQX: r_prod <= mul_p;
                tpla_pkg::OP_SQY: begin
                    r_prod <= mul_p;
                    r_acc  <= tpla_pkg::SQ_BITS'(r_prod);
                end
                tpla_pkg::OP_SQZ: begin
                    r_prod <= mul_p;
                    r_acc  <= r_acc + tpla_pkg::SQ_BITS'(r_prod);
                end
                tpla_pkg::OP_SUM: begin
                    r_acc  <= r_acc + tpla_pkg::SQ_BITS'(r_prod);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= tpla_pkg::CNT_BITS'(tpla_pkg::ROOT_BITS - 1);
                end
                tpla_pkg::OP_ROOT: begin
                    r_acc <= {r_acc[tpla_pkg::SQ_BITS-3:0], 2'b00};
                    r_cnt <= r_cnt - tpla_pkg::CNT_BITS'(1);
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[tpla_pkg::ROOT_BITS-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[tpla_pkg::ROOT_BITS-2:0], 1'b0};
                    end
                end
                tpla_pkg::OP_RND: begin
                    // Round half up: a remainder above the root means s > r^2 + r.
                    if (r_rem > tpla_pkg::REM_BITS'(r_root)) begin
                        r_root <= r_root + tpla_pkg::ROOT_BITS'(1);
                    end
                end
                tpla_pkg::OP_MLO: r_prod <= mul_p;
                tpla_pkg::OP_MHI: begin
                    r_prod <= mul_p;
                    r_rhs  <= tpla_pkg::RHS_BITS'(r_prod);
                end
                tpla_pkg::OP_MLH: begin
                    r_prod <= mul_p;
                    r_rhs  <= r_rhs + (tpla_pkg::RHS_BITS'(r_prod) << tpla_pkg::TIME_LO_BITS);
                end
                tpla_pkg::OP_CMP: r_pass <= (cmp_l < cmp_r);
                default: r_pass <= r_pass;
            endcase
        end
    end

    // Previous-sample flag, totals and inside state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
            r_path      <= '0;
            r_path_in   <= '0;
            r_inside    <= 1'b0;
        end else if (i_ctrl.exec && (i_ctrl.op == tpla_pkg::OP_ADD)) begin
            if (r_pass) begin
                r_path <= sat_add(r_path, r_root);
                if (r_inside) begin
                    r_path_in <= sat_add(r_path_in, r_root);
                end
            end
        end else if (i_ctrl.exec && (i_ctrl.op == tpla_pkg::OP_DONE)) begin
            r_path    <= o_res.total_path;
            r_path_in <= o_res.total_path_inside;
            r_inside  <= o_res.inside_flag;
            if (r_req == tpla_pkg::REQ_CLEAR) begin
                r_have_last <= 1'b0;
            end else if (is_sample) begin
                r_have_last <= 1'b1;
            end
        end
    end

    // Last position is meaningful only while a previous sample exists.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && (i_ctrl.op == tpla_pkg::OP_DONE) && is_sample) begin
            r_last_x <= r_x;
            r_last_y <= r_y;
            r_last_z <= r_z;
            r_last_t <= r_t;
        end
    end

endmodule

>>> sv/tool_path_length_accumulator.sv
// Tool path length odometer.
// Input stream: one beat per request. tuser carries the request kind (tool
// sample, enter, leave, clear); tdata carries the position and timestamp,
// which only tool samples use. Every input beat yields exactly one output
// beat with both totals, the step-added flag and the inside flag.
// A tool sample that measures a step runs the whole microprogram, whose length
// is set by the bit-serial square root that yields one root bit per cycle;
// the output beat is valid on the cycle after the last step, and a new input
// beat can be taken in that same cycle. Any other item skips from its first
// step straight to the finishing step.
// The input is not ready while an item is in progress. A finished result
// waits in the output register, so the next item is accepted and computed
// while the receiver stalls; only its final step waits for the register.
// Reset clears the totals, the inside state and the previous sample,
// disables recording and sets the speed limit to 500 mm/s. Configuration writes
// take effect at once; the user makes them only while no item is in progress, unchecked by the block.
`include "tool_path_length_accumulator_assert.svh"

module tool_path_length_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [tpla_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [tpla_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // Input stream.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // pos_x, pos_y, pos_z, sample_time
    input  logic [tpla_pkg::IN_DATA_BITS-1:0]     i_s_axis_tdata,
    // req_type
    input  logic [tpla_pkg::REQ_BITS-1:0]         i_s_axis_tuser,
    // Output stream.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // total_path, total_path_inside, step_added, inside_flag, zero pad
    output logic [tpla_pkg::OUT_DATA_BITS-1:0]    o_m_axis_tdata
);

    localparam int P = tpla_pkg::POSITION_BITS;

    logic                              r_rec_en;
    logic [tpla_pkg::SPEED_BITS-1:0]   r_max_speed;
    logic                              r_m_valid;
    tpla_pkg::t_res                    r_m_res;

    logic            start;
    logic            busy;
    logic            out_hold;
    logic            done;
    tpla_pkg::t_ctrl ctrl;
    tpla_pkg::t_stat stat;
    tpla_pkg::t_res  res;

    assign o_s_axis_tready = !busy;
    assign start           = i_s_axis_tvalid && !busy;
    assign out_hold        = r_m_valid && !i_m_axis_tready;
    assign done            = ctrl.exec && (ctrl.op == tpla_pkg::OP_DONE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_en    <= 1'b0;
            r_max_speed <= tpla_pkg::MAX_SPEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpla_pkg::CFG_RECORDING_ENABLE: r_rec_en    <= i_cfg_data[0];
                tpla_pkg::CFG_MAX_SPEED:        r_max_speed <= i_cfg_data;
                default:                        r_rec_en    <= r_rec_en;
            endcase
        end
    end

    tpla_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_hold (out_hold),
        .i_stat     (stat),
        .o_busy     (busy),
        .o_ctrl     (ctrl)
    );

    tpla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (start),
        .i_req       (i_s_axis_tuser),
        .i_pos_x     (i_s_axis_tdata[P-1:0]),
        .i_pos_y     (i_s_axis_tdata[2*P-1:P]),
        .i_pos_z     (i_s_axis_tdata[3*P-1:2*P]),
        .i_time      (i_s_axis_tdata[3*P+tpla_pkg::TIME_BITS-1:3*P]),
        .i_rec_en    (r_rec_en),
        .i_max_speed (r_max_speed),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_res       (res)
    );

    // Output register: loaded by the finishing step, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (done) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = tpla_pkg::OUT_DATA_BITS'(r_m_res);

    // Sequencer and output register agree.
    `TPLA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, start, !o_s_axis_tready, "input ready right after a beat was accepted")
    `TPLA_ASSERT_NXT(a_done_gives_beat, i_clk, i_rst_n, done, o_m_axis_tvalid, "finished item produced no output beat")
    `TPLA_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, done, !out_hold, "finishing step overwrote a pending output beat")

endmodule
